// File: rtl/mau_pkg.sv
package mau_pkg;

    localparam int MOD_WIDTH = 31;
    localparam int EXP_WIDTH = 63;
    localparam int RAW_WIDTH = 64;
    localparam int OP_WIDTH  = 3;
    localparam int ACC_WIDTH = MOD_WIDTH + 1;
    localparam int CNT_WIDTH = $clog2(RAW_WIDTH + 1);

    typedef logic [MOD_WIDTH-1:0] mod_t;
    typedef logic [ACC_WIDTH-1:0] acc_t;
    typedef logic [CNT_WIDTH-1:0] cnt_t;

    localparam mod_t MOD_RESET = mod_t'(1000000007);
    localparam mod_t MOD_ONE   = mod_t'(1);
    localparam mod_t MOD_TWO   = mod_t'(2);
    localparam cnt_t NBITS_MOD = cnt_t'(MOD_WIDTH);
    localparam cnt_t NBITS_RAW = cnt_t'(RAW_WIDTH);

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_MUL    = 3'd2,
        OP_DIV    = 3'd3,
        OP_POW    = 3'd4,
        OP_NEG    = 3'd5,
        OP_REDUCE = 3'd6
    } op_t;

    typedef struct packed {
        logic                 start;
        cnt_t                 nbits;
        logic [RAW_WIDTH-1:0] mult;
        mod_t                 x;
    } eng_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        mod_t prod;
    } eng_rsp_t;

    // left-align a residue in the multiplier shift register
    function automatic logic [RAW_WIDTH-1:0] align_mod(input mod_t v);
        return {v, {(RAW_WIDTH-MOD_WIDTH){1'b0}}};
    endfunction

endpackage

// File: rtl/mau_if.sv
interface mau_in_if import mau_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [OP_WIDTH-1:0]         operation;
    logic [MOD_WIDTH-1:0]        operand_a;
    logic [MOD_WIDTH-1:0]        operand_b;
    logic [EXP_WIDTH-1:0]        exponent;
    logic signed [RAW_WIDTH-1:0] raw_value;

    modport source (output valid, output operation, output operand_a, output operand_b,
                    output exponent, output raw_value, input ready);
    modport sink   (input valid, input operation, input operand_a, input operand_b,
                    input exponent, input raw_value, output ready);
endinterface

interface mau_out_if import mau_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [MOD_WIDTH-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

interface mau_cfg_if import mau_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [MOD_WIDTH-1:0] modulus;

    modport source (output valid, output modulus, input ready);
    modport sink   (input valid, input modulus, output ready);
endinterface

// File: rtl/modular_arithmetic_unit_core.sv
// Modular ALU over a configured modulus.
// Channels: cfg writes the modulus (reset value 1000000007); item carries one
// operation with its operands; res returns one residue per item. A beat moves
// on a rising edge where valid and ready are both high.
// Reductions and products are done by one bit-serial modular multiplier
// that handles one multiplier bit per cycle while a product is under way.
// Steps: add, sub, neg reduce both operands, then combine them; mul reduces
// both, then multiplies; reduce takes the 64-bit signed value's magnitude;
// pow squares and multiplies per exponent bit; div raises b to modulus-2,
// then multiplies a by it; modulus below two or an unused op gives zero.
// One item is processed at a time; item.ready is high only while the unit is
// idle. The finished result sits in an output register, so the next item is
// accepted while that result waits; if the receiver stalls longer, the
// following result waits in the unit until the output register frees up.
// Reset empties the unit, drops any pending result and restores the modulus.
// The modulus may only be written while no item is in flight.
module modular_arithmetic_unit_core import mau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mau_cfg_if.sink   cfg,
    mau_in_if.sink    item,
    mau_out_if.source res
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_RED_A     = 9'b000000010,
        S_RED_B     = 9'b000000100,
        S_RED_RAW   = 9'b000001000,
        S_POW_CHECK = 9'b000010000,
        S_POW_MUL   = 9'b000100000,
        S_POW_SQR   = 9'b001000000,
        S_MUL_LAST  = 9'b010000000,
        S_FINISH    = 9'b100000000
    } state_t;

    state_t               state_reg, state_next;
    mod_t                 modulus_reg;
    op_t                  op_reg, op_next;
    mod_t                 a_reg, a_next;
    mod_t                 b_reg, b_next;
    mod_t                 base_reg, base_next;
    mod_t                 acc_reg, acc_next;
    logic [EXP_WIDTH-1:0] exp_reg, exp_next;
    logic                 neg_reg, neg_next;
    mod_t                 res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    mod_t                 out_data_reg, out_data_next;

    eng_req_t             eng_req;
    eng_rsp_t             eng_rsp;

    logic                 mod_small;
    logic [RAW_WIDTH-1:0] raw_bits;
    logic [RAW_WIDTH-1:0] raw_mag;
    acc_t                 m_ext;
    acc_t                 add_sum;
    acc_t                 add_red;
    acc_t                 sub_wrap;
    mod_t                 bq;
    mod_t                 pq;
    mod_t                 sub_res;
    mod_t                 neg_res;
    mod_t                 raw_res;

    mau_mulser u_mulser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .req     (eng_req),
        .rsp     (eng_rsp)
    );

    always_comb
    begin
        mod_small = (modulus_reg[MOD_WIDTH-1:1] == '0);
        raw_bits  = item.raw_value;
        raw_mag   = raw_bits[RAW_WIDTH-1] ? (~raw_bits) + RAW_WIDTH'(1) : raw_bits;
        m_ext     = {1'b0, modulus_reg};
        bq        = eng_rsp.prod;
        pq        = eng_rsp.prod;
        add_sum   = {1'b0, a_reg} + {1'b0, bq};
        add_red   = (add_sum >= m_ext) ? add_sum - m_ext : add_sum;
        sub_wrap  = {1'b0, a_reg} + m_ext - {1'b0, bq};
        sub_res   = (a_reg >= bq) ? a_reg - bq : sub_wrap[MOD_WIDTH-1:0];
        neg_res   = (a_reg != '0) ? modulus_reg - a_reg : '0;
        raw_res   = (neg_reg && (pq != '0)) ? modulus_reg - pq : pq;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        exp_next       = exp_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        eng_req        = '{start: 1'b0, nbits: NBITS_MOD, mult: '0, x: MOD_ONE};

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    op_next  = op_t'(item.operation);
                    b_next   = item.operand_b;
                    exp_next = item.exponent;
                    neg_next = raw_bits[RAW_WIDTH-1];
                    if (mod_small)
                    begin
                        res_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        case (op_t'(item.operation))
                            OP_REDUCE:
                            begin
                                eng_req    = '{start: 1'b1, nbits: NBITS_RAW, mult: raw_mag,
                                               x: MOD_ONE};
                                state_next = S_RED_RAW;
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW, OP_NEG:
                            begin
                                eng_req    = '{start: 1'b1, nbits: NBITS_MOD,
                                               mult: align_mod(item.operand_a), x: MOD_ONE};
                                state_next = S_RED_A;
                            end
                            default:
                            begin
                                res_next   = '0;
                                state_next = S_FINISH;
                            end
                        endcase
                    end
                end
            end
            S_RED_A:
            begin
                if (eng_rsp.done)
                begin
                    a_next     = pq;
                    eng_req    = '{start: 1'b1, nbits: NBITS_MOD, mult: align_mod(b_reg),
                                   x: MOD_ONE};
                    state_next = S_RED_B;
                end
            end
            S_RED_B:
            begin
                if (eng_rsp.done)
                begin
                    b_next   = bq;
                    acc_next = MOD_ONE;
                    case (op_reg)
                        OP_ADD:
                        begin
                            res_next   = add_red[MOD_WIDTH-1:0];
                            state_next = S_FINISH;
                        end
                        OP_SUB:
                        begin
                            res_next   = sub_res;
                            state_next = S_FINISH;
                        end
                        OP_NEG:
                        begin
                            res_next   = neg_res;
                            state_next = S_FINISH;
                        end
                        OP_MUL:
                        begin
                            eng_req    = '{start: 1'b1, nbits: NBITS_MOD, mult: align_mod(bq),
                                           x: a_reg};
                            state_next = S_MUL_LAST;
                        end
                        OP_POW:
                        begin
                            base_next  = a_reg;
                            state_next = S_POW_CHECK;
                        end
                        OP_DIV:
                        begin
                            base_next  = bq;
                            exp_next   = {{(EXP_WIDTH-MOD_WIDTH){1'b0}}, modulus_reg - MOD_TWO};
                            state_next = S_POW_CHECK;
                        end
                        default:
                        begin
                            res_next   = '0;
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_RED_RAW:
            begin
                if (eng_rsp.done)
                begin
                    res_next   = raw_res;
                    state_next = S_FINISH;
                end
            end
            S_POW_CHECK:
            begin
                if (exp_reg == '0)
                begin
                    if (op_reg == OP_DIV)
                    begin
                        eng_req    = '{start: 1'b1, nbits: NBITS_MOD, mult: align_mod(a_reg),
                                       x: acc_reg};
                        state_next = S_MUL_LAST;
                    end
                    else
                    begin
                        res_next   = acc_reg;
                        state_next = S_FINISH;
                    end
                end
                else if (exp_reg[0])
                begin
                    eng_req    = '{start: 1'b1, nbits: NBITS_MOD, mult: align_mod(base_reg),
                                   x: acc_reg};
                    state_next = S_POW_MUL;
                end
                else
                begin
                    eng_req    = '{start: 1'b1, nbits: NBITS_MOD, mult: align_mod(base_reg),
                                   x: base_reg};
                    state_next = S_POW_SQR;
                end
            end
            S_POW_MUL:
            begin
                if (eng_rsp.done)
                begin
                    acc_next   = pq;
                    eng_req    = '{start: 1'b1, nbits: NBITS_MOD, mult: align_mod(base_reg),
                                   x: base_reg};
                    state_next = S_POW_SQR;
                end
            end
            S_POW_SQR:
            begin
                if (eng_rsp.done)
                begin
                    base_next  = pq;
                    exp_next   = exp_reg >> 1;
                    state_next = S_POW_CHECK;
                end
            end
            S_MUL_LAST:
            begin
                if (eng_rsp.done)
                begin
                    res_next   = pq;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= MOD_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                modulus_reg <= cfg.modulus;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        base_reg     <= base_next;
        acc_reg      <= acc_next;
        exp_reg      <= exp_next;
        neg_reg      <= neg_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign cfg.ready  = 1'b1;
    assign item.ready = (state_reg == S_IDLE);
    assign res.valid  = out_valid_reg;
    assign res.result = out_data_reg;

`ifndef SYNTHESIS
    a_start_idle_engine: assert property (@(posedge clk) disable iff (!rst_n)
        eng_req.start |-> !eng_rsp.busy)
        else $error("multiplier started while busy");

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        eng_rsp.done |-> (state_reg != S_IDLE) && (state_reg != S_FINISH))
        else $error("multiplier finished with no step waiting");

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !mod_small) |-> (res.result < modulus_reg))
        else $error("result not below modulus");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside finish step");
`endif

endmodule

// File: rtl/mau_mulser.sv
module mau_mulser import mau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_t     modulus,
    input  eng_req_t req,
    output eng_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    cnt_t                 cnt_reg, cnt_next;
    logic [RAW_WIDTH-1:0] sh_reg, sh_next;
    mod_t                 acc_reg, acc_next;
    mod_t                 x_reg, x_next;

    acc_t m_ext;
    acc_t dbl;
    acc_t dbl_red;
    acc_t sum;
    acc_t sum_red;

    // one multiplier bit per cycle, msb first: acc = 2*acc + bit*x mod m
    always_comb
    begin
        m_ext   = {1'b0, modulus};
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
        sum     = dbl_red + (sh_reg[RAW_WIDTH-1] ? {1'b0, x_reg} : acc_t'(0));
        sum_red = (sum >= m_ext) ? sum - m_ext : sum;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.nbits;
            sh_next   = req.mult;
            acc_next  = '0;
            x_next    = req.x;
        end
        else if (busy_reg)
        begin
            acc_next = sum_red[MOD_WIDTH-1:0];
            sh_next  = sh_reg << 1;
            cnt_next = cnt_reg - cnt_t'(1);
            if (cnt_reg == cnt_t'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule
